### src/spectral_peak_phase_interp_defines.svh
// assertion macros for the spectral peak interpolator
// no dependencies
`ifndef SPECTRAL_PEAK_PHASE_INTERP_DEFINES_SVH
`define SPECTRAL_PEAK_PHASE_INTERP_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define SPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/spi_pkg.sv
// shared types, constants and the cordic angle table
// no dependencies
package spi_pkg;

  localparam int BIN_FRAC_BITS     = 8;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int VW                = 27;
  localparam int KW                = BIN_FRAC_BITS + 1;
  localparam logic [3:0] LOG2_FFT_RESET = 4'd10;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [31:0]          ang;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic               channel;
    logic [KW-1:0]      kf;
    logic               ki_odd;
    logic [23:0]        mag_near;
    logic [23:0]        mag_far;
    logic signed [15:0] time_near;
    logic signed [15:0] time_far;
    logic [15:0]        freq;
  } side_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

### src/spi_if.sv
// valid/ready channel interfaces for peak items and results
// depends on nothing
interface spi_in_if;
  logic               valid;
  logic               ready;
  logic               channel;
  logic [19:0]        bin_position;
  logic [2:0]         band;
  logic [23:0]        mag_near;
  logic [23:0]        mag_far;
  logic signed [15:0] time_near;
  logic signed [15:0] time_far;
  logic signed [15:0] re_near;
  logic signed [15:0] im_near;
  logic signed [15:0] re_far;
  logic signed [15:0] im_far;
  modport source (output valid, channel, bin_position, band, mag_near, mag_far,
                  time_near, time_far, re_near, im_near, re_far, im_far,
                  input ready);
  modport sink (input valid, channel, bin_position, band, mag_near, mag_far,
                time_near, time_far, re_near, im_near, re_far, im_far,
                output ready);
endinterface

interface spi_out_if;
  logic               valid;
  logic               ready;
  logic               channel_out;
  logic [23:0]        interp_mag;
  logic signed [15:0] interp_time;
  logic [15:0]        phase;
  logic [15:0]        frequency;
  modport source (output valid, channel_out, interp_mag, interp_time, phase, frequency,
                  input ready);
  modport sink (input valid, channel_out, interp_mag, interp_time, phase, frequency,
                output ready);
endinterface

### src/spi_prep.sv
// first stage: nearest bin, fraction, frequency shift and cordic pre-rotation
// depends on spi_pkg
module spi_prep
  import spi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  logic               channel,
  input  logic [19:0]        bin_position,
  input  logic [2:0]         band,
  input  logic [23:0]        mag_near,
  input  logic [23:0]        mag_far,
  input  logic signed [15:0] time_near,
  input  logic signed [15:0] time_far,
  input  logic signed [15:0] re_near,
  input  logic signed [15:0] im_near,
  input  logic signed [15:0] re_far,
  input  logic signed [15:0] im_far,
  input  logic [3:0]         log2_fft,
  output logic               vld_r,
  output side_t              side_r,
  output vec_t               near_r,
  output vec_t               far_r
);

  localparam logic [BIN_FRAC_BITS-1:0] HALF_F = BIN_FRAC_BITS'(1) << (BIN_FRAC_BITS - 1);

  function automatic vec_t pre_rot(input logic signed [15:0] re, input logic signed [15:0] im);
    vec_t v;
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    xs = VW'(re) <<< 8;
    ys = VW'(im) <<< 8;
    v.zero = (re == 16'sd0) && (im == 16'sd0);
    if (xs < 0) begin
      v.x   = -xs;
      v.y   = -ys;
      v.ang = HALF_TURN;
    end else begin
      v.x   = xs;
      v.y   = ys;
      v.ang = 32'h0;
    end
    return v;
  endfunction

  logic [19-BIN_FRAC_BITS:0]  ip;
  logic [BIN_FRAC_BITS-1:0]   frac;
  logic                       round_up;
  logic [20:0]                ki;
  logic [20+BIN_FRAC_BITS:0]  kipos;
  logic [20+BIN_FRAC_BITS:0]  xw;
  logic [20+BIN_FRAC_BITS:0]  kdiff;
  logic signed [6:0]          sh;
  logic [35:0]                fwide;
  side_t                      side_nxt;

  always_comb begin
    ip       = bin_position[19:BIN_FRAC_BITS];
    frac     = bin_position[BIN_FRAC_BITS-1:0];
    round_up = (frac > HALF_F) || ((frac == HALF_F) && ip[0]);
    ki       = 21'(ip) + 21'(round_up);
    kipos    = (21+BIN_FRAC_BITS)'(ki) << BIN_FRAC_BITS;
    xw       = (21+BIN_FRAC_BITS)'(bin_position);
    kdiff    = (kipos < xw) ? (xw - kipos) : (kipos - xw);
    sh       = 7'(BIN_FRAC_BITS) + 7'(log2_fft) + 7'(band) - 7'sd16;
    if (sh <= 0) begin
      fwide = 36'(bin_position) << 6'(-sh);
    end else begin
      fwide = (36'(bin_position) + (36'(1) << 6'(sh - 7'sd1))) >> 6'(sh);
    end
    side_nxt.channel   = channel;
    side_nxt.kf        = kdiff[KW-1:0];
    side_nxt.ki_odd    = ki[0];
    side_nxt.mag_near  = mag_near;
    side_nxt.mag_far   = mag_far;
    side_nxt.time_near = time_near;
    side_nxt.time_far  = time_far;
    side_nxt.freq      = fwide[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      near_r <= pre_rot(re_near, im_near);
      far_r  <= pre_rot(re_far, im_far);
    end
  end

endmodule

### src/spi_cordic_stage.sv
// one registered cordic vectoring stage for both bins, sideband carried along
// depends on spi_pkg
module spi_cordic_stage
  import spi_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_in,
  input  side_t side_in,
  input  vec_t  near_in,
  input  vec_t  far_in,
  output logic  vld_r,
  output side_t side_r,
  output vec_t  near_r,
  output vec_t  far_r
);

  localparam logic [31:0] ATAN = atan_turn(5'(STAGE));

  function automatic vec_t rotate(input vec_t v);
    vec_t o;
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    xs = v.x >>> STAGE;
    ys = v.y >>> STAGE;
    o.zero = v.zero;
    if (v.y >= 0) begin
      o.x   = v.x + ys;
      o.y   = v.y - xs;
      o.ang = v.ang + ATAN;
    end else begin
      o.x   = v.x - ys;
      o.y   = v.y + xs;
      o.ang = v.ang - ATAN;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      near_r <= rotate(near_in);
      far_r  <= rotate(far_in);
    end
  end

endmodule

### src/spi_interp.sv
// phase unwrap and linear interpolation: select, multiply, sum and round
// depends on spi_pkg
module spi_interp
  import spi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  side_t              side_in,
  input  vec_t               near_in,
  input  vec_t               far_in,
  output logic               vld_r,
  output logic               channel_r,
  output logic [23:0]        mag_r,
  output logic signed [15:0] time_r,
  output logic [15:0]        phase_r,
  output logic [15:0]        freq_r
);

  localparam logic [KW-1:0] ONE_K  = KW'(1) << BIN_FRAC_BITS;
  localparam logic [KW-1:0] HALF_K = KW'(1) << (BIN_FRAC_BITS - 1);
  localparam int MW = KW + 24;
  localparam int TW = KW + 16;
  localparam int PW = 32 + KW + 1;

  // select stage
  logic          s1_vld_r;
  logic          s1_ch_r;
  logic [15:0]   s1_freq_r;
  logic [KW-1:0] s1_wn_r, s1_wf_r, s1_wp_r;
  logic [23:0]   s1_mn_r, s1_mf_r;
  logic [15:0]   s1_tn_r, s1_tf_r;
  logic [31:0]   s1_base_r, s1_d_r;
  logic [31:0]   ph0, ph1;
  logic          lo_half;

  always_comb begin
    ph0 = near_in.zero ? 32'h0 : near_in.ang;
    ph1 = far_in.zero ? 32'h0 : far_in.ang;
    if (side_in.ki_odd) begin
      ph0 = ph0 + HALF_TURN;
    end else begin
      ph1 = ph1 + HALF_TURN;
    end
    lo_half = side_in.kf < HALF_K;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ch_r   <= side_in.channel;
      s1_freq_r <= side_in.freq;
      s1_wn_r   <= ONE_K - side_in.kf;
      s1_wf_r   <= side_in.kf;
      s1_mn_r   <= side_in.mag_near;
      s1_mf_r   <= side_in.mag_far;
      s1_tn_r   <= side_in.time_near ^ 16'sh8000;
      s1_tf_r   <= side_in.time_far ^ 16'sh8000;
      s1_base_r <= lo_half ? ph0 : ph1;
      s1_d_r    <= lo_half ? (ph1 - ph0) : (ph0 - ph1);
      s1_wp_r   <= lo_half ? side_in.kf : (ONE_K - side_in.kf);
    end
  end

  // multiply stage
  logic                 s2_vld_r;
  logic                 s2_ch_r;
  logic [15:0]          s2_freq_r;
  logic [MW-1:0]        s2_pmn_r, s2_pmf_r;
  logic [TW-1:0]        s2_ptn_r, s2_ptf_r;
  logic signed [PW-1:0] s2_pp_r;
  logic [31:0]          s2_base_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ch_r   <= s1_ch_r;
      s2_freq_r <= s1_freq_r;
      s2_pmn_r  <= MW'(s1_wn_r) * MW'(s1_mn_r);
      s2_pmf_r  <= MW'(s1_wf_r) * MW'(s1_mf_r);
      s2_ptn_r  <= TW'(s1_wn_r) * TW'(s1_tn_r);
      s2_ptf_r  <= TW'(s1_wf_r) * TW'(s1_tf_r);
      s2_pp_r   <= PW'($signed(s1_d_r)) * $signed(PW'(s1_wp_r));
      s2_base_r <= s1_base_r;
    end
  end

  // sum and round stage, output register
  logic [MW:0]          msum;
  logic [TW:0]          tsum;
  logic signed [PW-1:0] pstep;
  logic [31:0]          res;
  logic [31:0]          rnd;

  always_comb begin
    msum  = (MW+1)'(s2_pmn_r) + (MW+1)'(s2_pmf_r) + (MW+1)'(HALF_K);
    tsum  = (TW+1)'(s2_ptn_r) + (TW+1)'(s2_ptf_r) + (TW+1)'(HALF_K);
    pstep = (s2_pp_r + $signed(PW'(HALF_K))) >>> BIN_FRAC_BITS;
    res   = s2_base_r + pstep[31:0];
    rnd   = res + 32'h0000_8000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      channel_r <= s2_ch_r;
      freq_r    <= s2_freq_r;
      mag_r     <= msum[BIN_FRAC_BITS +: 24];
      time_r    <= $signed(tsum[BIN_FRAC_BITS +: 16] ^ 16'h8000);
      phase_r   <= rnd[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_in;
      s2_vld_r <= s1_vld_r;
      vld_r    <= s2_vld_r;
    end
  end

endmodule

### src/spectral_peak_phase_interp.sv
// spectral peak interpolator top level: prep stage, cordic chain, interpolation
// depends on spi_pkg, spi_if, spi_prep, spi_cordic_stage, spi_interp and the defines
//
// usage
//   in_if carries one channel of one spectral peak per transfer: fractional bin,
//   band, and magnitude, time offset and complex value of the two neighbor bins.
//   out_if returns one result per item: interpolated magnitude, time offset and
//   phase, and the peak frequency.
//   cfg_we/cfg_wdata write log2 of the transform length; write only while idle.
//   from input transfer to output valid an item passes through the prep stage, one
//   stage per cordic step, then the select, multiply and sum/output stages.
//   throughput is one item per cycle unless stalled; the cordic chain sets the depth.
//   the whole pipeline advances whenever the output register is empty or taken,
//   so in_if.ready follows out_if.ready; a stall holds every stage in place.
//   reset clears all valid bits and sets the transform size to 1024.
`include "spectral_peak_phase_interp_defines.svh"
module spectral_peak_phase_interp
  import spi_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  spi_in_if.sink     in_if,
  spi_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  logic       en;
  logic [3:0] log2_r;

  logic  vld  [0:CORDIC_STAGES];
  side_t side [0:CORDIC_STAGES];
  vec_t  nv   [0:CORDIC_STAGES];
  vec_t  fv   [0:CORDIC_STAGES];

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r <= LOG2_FFT_RESET;
    end else if (cfg_we) begin
      log2_r <= cfg_wdata;
    end
  end

  spi_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .vld_in       (in_if.valid),
    .channel      (in_if.channel),
    .bin_position (in_if.bin_position),
    .band         (in_if.band),
    .mag_near     (in_if.mag_near),
    .mag_far      (in_if.mag_far),
    .time_near    (in_if.time_near),
    .time_far     (in_if.time_far),
    .re_near      (in_if.re_near),
    .im_near      (in_if.im_near),
    .re_far       (in_if.re_far),
    .im_far       (in_if.im_far),
    .log2_fft     (log2_r),
    .vld_r        (vld[0]),
    .side_r       (side[0]),
    .near_r       (nv[0]),
    .far_r        (fv[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    spi_cordic_stage #(.STAGE(i)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld[i]),
      .side_in (side[i]),
      .near_in (nv[i]),
      .far_in  (fv[i]),
      .vld_r   (vld[i+1]),
      .side_r  (side[i+1]),
      .near_r  (nv[i+1]),
      .far_r   (fv[i+1])
    );
  end

  spi_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (vld[CORDIC_STAGES]),
    .side_in   (side[CORDIC_STAGES]),
    .near_in   (nv[CORDIC_STAGES]),
    .far_in    (fv[CORDIC_STAGES]),
    .vld_r     (out_if.valid),
    .channel_r (out_if.channel_out),
    .mag_r     (out_if.interp_mag),
    .time_r    (out_if.interp_time),
    .phase_r   (out_if.phase),
    .freq_r    (out_if.frequency)
  );

  // checks
  `SPI_ASSERT_NEXT(a_cfg_write, cfg_we, log2_r == $past(cfg_wdata), "cfg write lost")
  `SPI_ASSERT_NEXT(a_stall_hold, !en, $stable(vld[CORDIC_STAGES]) && $stable(vld[0]), "stage moved in stall")
  `SPI_ASSERT_NOW(a_rise_adv, $rose(out_if.valid), $past(en), "result appeared during stall")
  `SPI_ASSERT_NEXT(a_prep_fill, en && in_if.valid, vld[0], "accepted item dropped")

endmodule
